>>> design/ppb_pkg.sv
package ppb_pkg;

  // Channel and coverage constants
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CovW    = 9;
  localparam int unsigned NumChan = 3;
  localparam logic [ChanW-1:0] ChanMax = 8'd255;
  localparam logic [CovW-1:0]  CovFull = 9'd256;

  // Register map: one 32-bit register, selected by the word bit of paddr
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam logic RegBlendMode = 1'b0;

  // Pipeline layout
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages = ChanW / DivBitsPerStage;
  localparam int unsigned StgIn       = 0;
  localparam int unsigned StgDivFirst = 1;
  localparam int unsigned StgDivLast  = DivStages;
  localparam int unsigned StgTgt      = DivStages + 1;
  localparam int unsigned StgDiff     = DivStages + 2;
  localparam int unsigned StgScale    = DivStages + 3;
  localparam int unsigned StgOut      = DivStages + 4;
  localparam int unsigned NumStages   = DivStages + 5;

  typedef enum logic [1:0] {
    MODE_REPLACE = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_MIX     = 2'd2,
    MODE_MULT    = 2'd3
  } mode_e;

  typedef logic [NumChan-1:0][ChanW-1:0] chan_t;

  // Everything an item carries down the pipeline; each stage fills its part
  typedef struct packed {
    mode_e                            mode;
    logic                             black;
    logic [CovW-1:0]                  cov;
    logic [ChanW-1:0]                 mx;
    chan_t                            old;
    chan_t                            paint;
    chan_t                            rem;
    chan_t                            lo;
    chan_t                            quo;
    logic [NumChan-1:0][2*ChanW-1:0]  prod;
    chan_t                            tgt;
    logic [NumChan-1:0][ChanW:0]      opnd;
    logic [NumChan-1:0][ChanW+1:0]    step;
    chan_t                            res;
  } stage_t;

  // floor(x / 255) for x up to 255*255, i.e. any product of two channels
  function automatic logic [ChanW-1:0] div255(input logic [2*ChanW-1:0] x);
    logic [2*ChanW:0] s;
    s = {1'b0, x} + {{(ChanW+1){1'b0}}, x[2*ChanW-1:ChanW]} + {{(2*ChanW){1'b0}}, 1'b1};
    return s[2*ChanW-1:ChanW];
  endfunction

endpackage

>>> design/pixel_paint_blend.sv
// Pixel paint blender.
// Input channel (in_valid_i / in_ready_o) takes one request per cycle: the old
// pixel, the paint colour and a coverage of 0..256 (values above 256 count as
// 256). Output channel (out_valid_o / out_ready_i) returns the blended pixel.
// The blend mode is an APB register at byte address 0 (replace, additive
// saturating, mix average, multiply); write it only while no request is in
// flight.
// Throughput is one pixel per cycle while out_ready_i is high. The depth is set
// by the normalising divide (old*255/max), done as a restoring divider of two
// quotient bits per stage over four stages, between a capture stage and the
// target/product, distance, scale and final add stages.
// Each stage holds its request while the next one is full and stalled, so a
// stall on out_ready_i backs up stage by stage without losing or repeating a
// request; empty stages keep filling, so in_ready_o drops only once every
// stage holds a request.
// Reset clears all stage valid bits and sets the mode to replace.
module pixel_paint_blend (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppb_pkg::PaddrW-1:0]    paddr,
  input  logic [ppb_pkg::PdataW-1:0]    pwdata,
  output logic [ppb_pkg::PdataW-1:0]    prdata,
  output logic                          pready,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ppb_pkg::ChanW-1:0]     old_red_i,
  input  logic [ppb_pkg::ChanW-1:0]     old_green_i,
  input  logic [ppb_pkg::ChanW-1:0]     old_blue_i,
  input  logic [ppb_pkg::ChanW-1:0]     paint_red_i,
  input  logic [ppb_pkg::ChanW-1:0]     paint_green_i,
  input  logic [ppb_pkg::ChanW-1:0]     paint_blue_i,
  input  logic [ppb_pkg::CovW-1:0]      coverage_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ppb_pkg::ChanW-1:0]     new_red_o,
  output logic [ppb_pkg::ChanW-1:0]     new_green_o,
  output logic [ppb_pkg::ChanW-1:0]     new_blue_o
);

  localparam int unsigned NumStg = ppb_pkg::NumStages;
  localparam int unsigned ChanW  = ppb_pkg::ChanW;
  localparam int unsigned NumCh  = ppb_pkg::NumChan;

  ppb_pkg::mode_e  mode_q;
  logic            reg_hit;

  logic [NumStg-1:0]  vld_q;
  logic [NumStg-1:0]  adv;
  ppb_pkg::stage_t    stg_q [NumStg];
  ppb_pkg::stage_t    stg_d [NumStg];

  // Register port: always ready, write in the access phase
  assign reg_hit = (paddr[2] == ppb_pkg::RegBlendMode);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(ppb_pkg::PdataW-2){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ppb_pkg::MODE_REPLACE;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      mode_q <= ppb_pkg::mode_e'(pwdata[1:0]);
    end
  end

  // A stage loads when it is empty or its contents move on
  always_comb begin
    adv[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStg-1];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStg; k++) begin
      if (adv[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // Capture: clamp coverage, find the brightest channel, form old*255
  always_comb begin
    ppb_pkg::stage_t s;
    logic [2*ChanW-1:0] num;
    s = '0;
    s.mode  = mode_q;
    s.old   = {old_blue_i, old_green_i, old_red_i};
    s.paint = {paint_blue_i, paint_green_i, paint_red_i};
    s.cov   = (coverage_i > ppb_pkg::CovFull) ? ppb_pkg::CovFull : coverage_i;
    s.mx    = old_red_i;
    if (old_green_i > s.mx) begin
      s.mx = old_green_i;
    end
    if (old_blue_i > s.mx) begin
      s.mx = old_blue_i;
    end
    s.black = (s.mx == '0);
    for (int c = 0; c < NumCh; c++) begin
      num = {s.old[c], {ChanW{1'b0}}} - {{ChanW{1'b0}}, s.old[c]};
      s.rem[c] = num[2*ChanW-1:ChanW];
      s.lo[c]  = num[ChanW-1:0];
    end
    stg_d[ppb_pkg::StgIn] = s;
  end

  // Divide old*255 by the brightest channel, two quotient bits per stage
  for (genvar k = ppb_pkg::StgDivFirst; k <= ppb_pkg::StgDivLast; k++) begin : g_div
    always_comb begin
      ppb_pkg::stage_t s;
      logic [ChanW:0]   t9;
      logic [ChanW-1:0] r;
      logic [ChanW-1:0] q;
      logic [ChanW-1:0] l;
      s = stg_q[k-1];
      for (int c = 0; c < NumCh; c++) begin
        r = s.rem[c];
        q = s.quo[c];
        l = s.lo[c];
        for (int b = 0; b < ppb_pkg::DivBitsPerStage; b++) begin
          t9 = {r, l[ChanW-1]};
          l  = {l[ChanW-2:0], 1'b0};
          if (t9 >= {1'b0, s.mx}) begin
            t9 = t9 - {1'b0, s.mx};
            q  = {q[ChanW-2:0], 1'b1};
          end else begin
            q  = {q[ChanW-2:0], 1'b0};
          end
          r = t9[ChanW-1:0];
        end
        s.rem[c] = r;
        s.quo[c] = q;
        s.lo[c]  = l;
      end
      stg_d[k] = s;
    end
  end

  // Target for replace and mix, product for multiply
  always_comb begin
    ppb_pkg::stage_t s;
    logic [ChanW:0] sum9;
    s = stg_q[ppb_pkg::StgTgt-1];
    for (int c = 0; c < NumCh; c++) begin
      s.prod[c] = {{ChanW{1'b0}}, s.quo[c]} * {{ChanW{1'b0}}, s.paint[c]};
      sum9 = {1'b0, s.quo[c]} + {1'b0, s.paint[c]};
      if (s.mode == ppb_pkg::MODE_REPLACE || s.black) begin
        s.tgt[c] = s.paint[c];
      end else begin
        s.tgt[c] = sum9[ChanW:1];
      end
    end
    stg_d[ppb_pkg::StgTgt] = s;
  end

  // Final target and the signed distance to move (paint itself when adding)
  always_comb begin
    ppb_pkg::stage_t s;
    logic [ChanW-1:0] t;
    s = stg_q[ppb_pkg::StgDiff-1];
    for (int c = 0; c < NumCh; c++) begin
      if (s.mode == ppb_pkg::MODE_MULT && !s.black) begin
        t = ppb_pkg::div255(s.prod[c]);
      end else begin
        t = s.tgt[c];
      end
      if (s.mode == ppb_pkg::MODE_ADD) begin
        s.opnd[c] = {1'b0, s.paint[c]};
      end else begin
        s.opnd[c] = {1'b0, t} - {1'b0, s.old[c]};
      end
    end
    stg_d[ppb_pkg::StgDiff] = s;
  end

  // Scale by coverage and floor-divide by 256
  always_comb begin
    ppb_pkg::stage_t s;
    logic signed [2*ChanW+2:0] p;
    s = stg_q[ppb_pkg::StgScale-1];
    for (int c = 0; c < NumCh; c++) begin
      p = $signed(s.opnd[c]) * $signed({1'b0, s.cov});
      s.step[c] = p[2*ChanW+1:ChanW];
    end
    stg_d[ppb_pkg::StgScale] = s;
  end

  // Apply the step and saturate at full scale
  always_comb begin
    ppb_pkg::stage_t s;
    logic [ChanW+1:0] sum;
    s = stg_q[ppb_pkg::StgOut-1];
    for (int c = 0; c < NumCh; c++) begin
      sum = {2'b00, s.old[c]} + s.step[c];
      s.res[c] = sum[ChanW] ? ppb_pkg::ChanMax : sum[ChanW-1:0];
    end
    stg_d[ppb_pkg::StgOut] = s;
  end

  assign new_red_o   = stg_q[NumStg-1].res[0];
  assign new_green_o = stg_q[NumStg-1].res[1];
  assign new_blue_o  = stg_q[NumStg-1].res[2];

endmodule
